[src/bafa_pkg.sv]
package bafa_pkg;

  // Field widths fixed by the request, response and configuration formats
  localparam int IDX_W    = 10;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 11;

  // Default pool geometry and register reset
  localparam int                 POOL_DEPTH_DEFAULT = 1024;
  localparam logic [CFG_W-1:0]   POOL_SIZE_RESET    = 11'd1024;

  // Request actions
  localparam logic [ACTION_W-1:0] ACTION_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACTION_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACTION_CLEAR = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_STACK_FULL = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic take;      // request beat accepted this cycle
    logic load_pop;  // load the response from the stack read data
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_pop;    // current request pops the free stack
  } dp_status_t;

endpackage

[src/bafa_req_if.sv]
interface bafa_req_if;
  import bafa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [IDX_W-1:0]    slot_index;

  modport source (output valid, output action, output slot_index, input ready);
  modport sink   (input valid, input action, input slot_index, output ready);
endinterface

[src/bafa_rsp_if.sv]
interface bafa_rsp_if;
  import bafa_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    granted_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_index, output status, input ready);
  modport sink   (input valid, input granted_index, input status, output ready);
endinterface

[src/bump_and_free_list_allocator_top.sv]
// Channel   Dir  Fields                      Beat
// req_i     in   action, slot_index          valid && ready
// rsp_o     out  granted_index, status       valid && ready
// cfg       in   cfg_wdata_i (pool_size)     cfg_we_i
//
// One request every cycle for free, clear and bump allocations while the
// response drains; a pop waits in POP for the registered stack memory read.
// Reset clears the pointers and the response valid; the stack memory is not
// cleared, since only entries below the fill count are read.
// A stalled response or a pending pop holds the block: a new request is taken
// only in IDLE while the response register is empty or drains in that cycle.
module bump_and_free_list_allocator_top #(
  parameter int POOL_DEPTH = bafa_pkg::POOL_DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bafa_pkg::CFG_W-1:0]  cfg_wdata_i,
  bafa_req_if.sink                    req_i,
  bafa_rsp_if.source                  rsp_o
);
  import bafa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  bafa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  bafa_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (req_i.action),
    .slot_index_i    (req_i.slot_index),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .granted_index_o (rsp_o.granted_index),
    .status_code_o   (rsp_o.status)
  );

endmodule

[src/bafa_ctrl.sv]
module bafa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  bafa_pkg::dp_status_t  status_i,
  output bafa_pkg::ctrl_cmd_t   cmd_o
);
  import bafa_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // The response register can take a beat when empty or draining now
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    in_ready_o    = 1'b0;
    cmd_o.take    = 1'b0;
    cmd_o.load_pop = 1'b0;

    // Drop the response once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          cmd_o.take = 1'b1;
          if (status_i.is_pop) begin
            state_d = ST_POP;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_POP: begin
        // Hold the read data until the response register frees up
        if (out_free) begin
          cmd_o.load_pop = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/bafa_datapath.sv]
module bafa_datapath #(
  parameter int POOL_DEPTH = bafa_pkg::POOL_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bafa_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [bafa_pkg::ACTION_W-1:0]  action_i,
  input  logic [bafa_pkg::IDX_W-1:0]     slot_index_i,
  input  bafa_pkg::ctrl_cmd_t            cmd_i,
  output bafa_pkg::dp_status_t           status_o,
  output logic [bafa_pkg::IDX_W-1:0]     granted_index_o,
  output logic [bafa_pkg::STATUS_W-1:0]  status_code_o
);
  import bafa_pkg::*;

  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int ADR_W = $clog2(POOL_DEPTH);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]    pool_size_q;
  logic [CNT_W-1:0]    free_count_q, free_count_d;
  logic [CNT_W-1:0]    bump_next_q, bump_next_d;
  logic [CNT_W-1:0]    count_dec;
  logic [CMP_W-1:0]    pool_limit;
  logic                stack_empty, stack_full, bump_ok, slot_ok;
  logic                is_pop, push_en;
  logic [IDX_W-1:0]    gnt_d, gnt_q;
  logic [STATUS_W-1:0] st_d, st_q;
  logic [IDX_W-1:0]    stack_mem [POOL_DEPTH];
  logic [IDX_W-1:0]    rd_data_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= POOL_SIZE_RESET;
    end else if (cfg_we_i) begin
      pool_size_q <= cfg_wdata_i;
    end
  end

  // Decode the request against the current pointers
  assign count_dec   = free_count_q - CNT_W'(1);
  assign stack_empty = (free_count_q == '0);
  assign stack_full  = (free_count_q == CNT_W'(POOL_DEPTH));
  assign pool_limit  = (CMP_W'(pool_size_q) > CMP_W'(POOL_DEPTH))
                       ? CMP_W'(POOL_DEPTH) : CMP_W'(pool_size_q);
  assign bump_ok     = (CMP_W'(bump_next_q) < pool_limit);
  assign slot_ok     = (CMP_W'(slot_index_i) < CMP_W'(bump_next_q));
  assign is_pop      = (action_i == ACTION_ALLOC) && !stack_empty;
  assign push_en     = cmd_i.take && (action_i == ACTION_FREE) && slot_ok && !stack_full;
  assign status_o.is_pop = is_pop;

  always_comb begin
    free_count_d = free_count_q;
    bump_next_d  = bump_next_q;
    gnt_d        = '0;
    st_d         = STATUS_OK;
    case (action_i)
      ACTION_ALLOC: begin
        if (!stack_empty) begin
          free_count_d = count_dec;
        end else if (bump_ok) begin
          gnt_d       = IDX_W'(bump_next_q);
          bump_next_d = bump_next_q + CNT_W'(1);
        end else begin
          st_d = STATUS_EXHAUSTED;
        end
      end
      ACTION_FREE: begin
        if (!slot_ok) begin
          st_d = STATUS_BAD_FREE;
        end else if (stack_full) begin
          st_d = STATUS_STACK_FULL;
        end else begin
          free_count_d = free_count_q + CNT_W'(1);
        end
      end
      ACTION_CLEAR: begin
        free_count_d = '0;
        bump_next_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // Advance the pointers on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q <= '0;
      bump_next_q  <= '0;
    end else if (cmd_i.take) begin
      free_count_q <= free_count_d;
      bump_next_q  <= bump_next_d;
    end
  end

  // Free stack: push on a valid free, registered read on a pop
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[free_count_q[ADR_W-1:0]] <= slot_index_i;
    end
    if (cmd_i.take && is_pop) begin
      rd_data_q <= stack_mem[count_dec[ADR_W-1:0]];
    end
  end

  // Response payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pop) begin
      gnt_q <= rd_data_q;
      st_q  <= STATUS_OK;
    end else if (cmd_i.take && !is_pop) begin
      gnt_q <= gnt_d;
      st_q  <= st_d;
    end
  end

  assign granted_index_o = gnt_q;
  assign status_code_o   = st_q;

endmodule

[sim/tb_top.sv]
module tb_top;
  import bafa_pkg::*;

  localparam int POOL_DEPTH      = POOL_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_PHASES   = 9;
  localparam int PHASE_ITEMS     = 88;

  // Action code with no function in the block
  localparam logic [ACTION_W-1:0] ACTION_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]    granted;
    logic [STATUS_W-1:0] status;
  } alloc_rsp_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  bafa_req_if req_if ();
  bafa_rsp_if rsp_if ();

  bump_and_free_list_allocator_top #(
    .POOL_DEPTH(POOL_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Shadow allocator state
  logic [IDX_W-1:0] stack_mem [POOL_DEPTH];
  logic [CFG_W-1:0] stack_fill  = '0;
  logic [CFG_W-1:0] bump_mark   = '0;
  logic [CFG_W-1:0] pool_size_q = POOL_SIZE_RESET;

  alloc_rsp_t pending_grants[$];

  bit idle_on         = 1'b1;
  int hold_off_cycles = 0;
  int n_sent          = 0;
  int n_checked       = 0;
  int n_errors        = 0;
  int n_granted       = 0;
  int n_exhausted     = 0;
  int n_bad_free      = 0;
  int n_stack_full    = 0;
  int n_cfg_writes    = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Work out the response of one accepted request and advance the shadow state
  function automatic alloc_rsp_t next_grant(input logic [ACTION_W-1:0] act,
                                            input logic [IDX_W-1:0]    slot);
    alloc_rsp_t  r;
    int unsigned limit;
    r     = '0;
    limit = (pool_size_q > POOL_DEPTH) ? POOL_DEPTH : pool_size_q;
    case (act)
      ACTION_ALLOC: begin
        if (stack_fill != 0 && stack_fill <= POOL_DEPTH) begin
          stack_fill = stack_fill - CFG_W'(1);
          r.granted  = stack_mem[stack_fill[IDX_W-1:0]];
        end else if (bump_mark < limit) begin
          r.granted = bump_mark[IDX_W-1:0];
          bump_mark = bump_mark + CFG_W'(1);
        end else begin
          r.status = STATUS_EXHAUSTED;
        end
      end
      ACTION_FREE: begin
        if ({1'b0, slot} >= bump_mark) begin
          r.status = STATUS_BAD_FREE;
        end else if (stack_fill >= POOL_DEPTH) begin
          r.status = STATUS_STACK_FULL;
        end else begin
          stack_mem[stack_fill[IDX_W-1:0]] = slot;
          stack_fill = stack_fill + CFG_W'(1);
        end
      end
      ACTION_CLEAR: begin
        bump_mark  = '0;
        stack_fill = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request beat, with an optional gap, and log its response once taken
  task automatic send_req(input logic [ACTION_W-1:0] act, input logic [IDX_W-1:0] slot);
    int         gap;
    alloc_rsp_t rsp;
    if (idle_on && $urandom_range(99) < 24) begin
      gap = $urandom_range(1, 4);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.slot_index <= slot;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    rsp = next_grant(act, slot);
    pending_grants.insert(pending_grants.size(), rsp);
    n_sent++;
  endtask

  // Drop valid and wait until every response has drained
  task automatic settle_idle();
    req_if.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_pool_size(input logic [CFG_W-1:0] size);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    pool_size_q = size;
    n_cfg_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // Bump grants, invalid frees, double free, unknown action, clear
  task automatic test_directed();
    send_req(ACTION_FREE, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_ALLOC, 10'h3FF);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_FREE, 10'd1);
    send_req(ACTION_FREE, 10'd1);
    send_req(ACTION_FREE, 10'd3);
    send_req(ACTION_FREE, 10'h3FF);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_UNUSED, 10'h3FF);
    send_req(ACTION_FREE, 10'h2AA);
    send_req(ACTION_CLEAR, 10'h155);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_FREE, '0);
    send_req(ACTION_ALLOC, '0);
  endtask

  // Tiny pools, a limit lowered under the bump mark, and a zero limit
  task automatic test_pool_limits();
    int i;
    set_pool_size(11'd1);
    send_req(ACTION_CLEAR, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_FREE, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_FREE, 10'd1);
    set_pool_size(11'd8);
    for (i = 0; i < 5; i++) send_req(ACTION_ALLOC, '0);
    set_pool_size(11'd2);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_FREE, 10'd5);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_FREE, 10'd3);
    send_req(ACTION_FREE, 10'd4);
    set_pool_size(11'd0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_FREE, 10'd2);
    send_req(ACTION_ALLOC, '0);
  endtask

  // Limit above depth: bump grants, a free and a pop, an invalid free, clear
  task automatic test_large_limit();
    int i;
    set_pool_size(11'd2047);
    send_req(ACTION_CLEAR, '0);
    for (i = 0; i < 6; i++) send_req(ACTION_ALLOC, '0);
    send_req(ACTION_FREE, 10'd5);
    send_req(ACTION_FREE, 10'h3FF);
    send_req(ACTION_ALLOC, '0);
    send_req(ACTION_CLEAR, '0);
  endtask

  // Random traffic over several pool sizes, with a no-idle phase, a long
  // response hold-off and a sender pause until everything has drained
  task automatic test_random();
    int               phase;
    int               i;
    int               pick;
    logic [CFG_W-1:0] size;
    logic [ACTION_W-1:0] act;
    logic [IDX_W-1:0]    slot;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       size = 11'd5;
        1:       size = 11'd0;
        2:       size = 11'd2047;
        3:       size = CFG_W'($urandom_range(2, 40));
        4:       size = 11'd1024;
        5:       size = 11'd1;
        6:       size = CFG_W'($urandom_range(0, 2047));
        7:       size = CFG_W'($urandom_range(8, 24));
        default: size = 11'd3;
      endcase
      set_pool_size(size);
      idle_on = (phase != 2);
      if (phase == 4) hold_off_cycles = HOLD_OFF_CYCLES;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 6 && i == PHASE_ITEMS / 2) settle_idle();
        pick = $urandom_range(99);
        if (pick < 46)      act = ACTION_ALLOC;
        else if (pick < 93) act = ACTION_FREE;
        else if (pick < 97) act = ACTION_CLEAR;
        else                act = ACTION_UNUSED;
        // Mostly free slots that were handed out, sometimes any slot
        if (bump_mark != 0 && $urandom_range(99) < 85)
          slot = IDX_W'($urandom_range(int'(bump_mark) - 1));
        else
          slot = IDX_W'($urandom());
        send_req(act, slot);
      end
    end
    idle_on = 1'b1;
  endtask

  // Response sink: random stalls, plus a counted hold-off when requested
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_off_cycles--;
      end else if (idle_on) begin
        rsp_if.ready <= ($urandom_range(99) >= 24);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each response beat with the oldest prediction
  always @(posedge clk_i) begin : rsp_check
    alloc_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: response with none pending: granted %0d status %0d",
                 $time, rsp_if.granted_index, rsp_if.status);
        n_errors++;
      end else begin
        want = pending_grants.pop_front();
        n_checked++;
        if (rsp_if.granted_index !== want.granted) begin
          $display("%0t: granted_index expected %0d actual %0d",
                   $time, want.granted, rsp_if.granted_index);
          n_errors++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, rsp_if.status);
          n_errors++;
        end
        case (want.status)
          STATUS_EXHAUSTED:  n_exhausted++;
          STATUS_BAD_FREE:   n_bad_free++;
          STATUS_STACK_FULL: n_stack_full++;
          default:           n_granted++;
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout with %0d responses outstanding", $time, pending_grants.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    req_if.valid      <= 1'b0;
    req_if.action     <= ACTION_ALLOC;
    req_if.slot_index <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_pool_limits();
    test_large_limit();
    test_random();
    settle_idle();

    $display("Ran %0d requests over %0d pool size settings, %0d responses checked",
             n_sent, n_cfg_writes, n_checked);
    $display("Saw %0d ok, %0d exhausted, %0d invalid frees, %0d stack-full drops",
             n_granted, n_exhausted, n_bad_free, n_stack_full);
    if (n_errors == 0 && pending_grants.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bafa_pkg.sv
src/bafa_req_if.sv
src/bafa_rsp_if.sv
src/bafa_ctrl.sv
src/bafa_datapath.sv
src/bump_and_free_list_allocator_top.sv
sim/tb_top.sv
